// File: hw/rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies; imported by spq_cell and sorted_priority_queue
`default_nettype none

package spq_pkg;

  localparam int unsigned SpqDepth   = 16;
  localparam int unsigned SpqKeyBits = 16;
  localparam int unsigned SpqTagBits = 16;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_POLL       = 3'd1,
    OP_PEEK       = 3'd2,
    OP_READ_AT    = 3'd3,
    OP_REMOVE_TAG = 3'd4,
    OP_REMOVE_AT  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_TAKE_LEFT  = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } cell_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  typedef struct packed {
    cell_cmd_e cmd;
  } cell_ctrl_t;

  typedef struct packed {
    logic gt;
    logic match;
  } cell_flags_t;

  // input word, first field in the highest bits
  typedef struct packed {
    logic        pad;
    logic [3:0]  position;
    logic [15:0] payload_tag;
    logic [15:0] priority_key;
    op_e         opcode;
  } in_word_t;

  // output word, first field in the highest bits
  typedef struct packed {
    logic [4:0]  entry_count;
    logic [4:0]  removed_count;
    logic [3:0]  out_position;
    logic [15:0] out_key;
    logic [15:0] out_payload;
    status_e     status;
  } out_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_cell.sv
// one queue cell: holds a key and a tag, loads, holds or takes a neighbor entry
// depends on spq_pkg
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned KEY_BITS = SpqKeyBits,
  parameter int unsigned TAG_BITS = SpqTagBits
) (
  input  wire logic                clk_i,
  input  wire cell_ctrl_t          ctrl_i,
  input  wire logic [KEY_BITS-1:0] new_key_i,
  input  wire logic [TAG_BITS-1:0] new_tag_i,
  input  wire logic [KEY_BITS-1:0] left_key_i,
  input  wire logic [TAG_BITS-1:0] left_tag_i,
  input  wire logic [KEY_BITS-1:0] right_key_i,
  input  wire logic [TAG_BITS-1:0] right_tag_i,
  output logic      [KEY_BITS-1:0] key_o,
  output logic      [TAG_BITS-1:0] tag_o,
  output cell_flags_t              flags_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  always_comb begin
    unique case (ctrl_i.cmd)
      CELL_LOAD: begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end
      CELL_TAKE_LEFT: begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end
      CELL_TAKE_RIGHT: begin
        key_d = right_key_i;
        tag_d = right_tag_i;
      end
      default: begin
        key_d = key_q;
        tag_d = tag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o         = key_q;
  assign tag_o         = tag_q;
  assign flags_o.gt    = (key_q > new_key_i);
  assign flags_o.match = (tag_q == new_tag_i);

endmodule

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
// sorted priority queue top level: row of spq_cell entries plus sequencer
// depends on spq_pkg and spq_cell
//
// usage: one command word enters on the s_axis group, one result word leaves on
// the m_axis group for every command. entries stay sorted by ascending key,
// equal keys in arrival order, shifting one place between neighbor cells.
// insert, poll, peek, read at and remove at finish in the accept cycle; the
// result word is valid on the next cycle. remove by tag walks a scan pointer
// down the cell row, one entry per cycle, removing each entry whose tag matches,
// and loads the result word once the pointer passes the last stored entry.
// a new command is taken only with the sequencer idle and the result register
// free or being read in the same cycle; a stalled receiver holds the result
// word and blocks further commands without losing anything.
// reset empties the queue and drops any pending result; entry contents are not
// cleared and are never read before written.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH    = SpqDepth,
  parameter int unsigned KEY_BITS = SpqKeyBits,
  parameter int unsigned TAG_BITS = SpqTagBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // opcode, priority_key, payload_tag, position, one pad bit
  input  wire logic [39:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status, out_payload, out_key, out_position, removed_count, entry_count
  output logic      [47:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  in_word_t  in_w;
  out_word_t out_q, out_d;
  logic      out_load;
  logic      m_valid_q;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic [CntW-1:0]   rcnt_q, rcnt_d;
  logic [TAG_BITS-1:0] tag_q;

  logic [31:0]         key_ext, tag_ext;
  logic [KEY_BITS-1:0] bus_key;
  logic [TAG_BITS-1:0] in_tag, bus_tag;
  logic                in_fire;
  logic                pos_ok;
  logic [IdxW-1:0]     pos_idx, scan_idx, ins_pos;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [TAG_BITS-1:0] cell_tag [DEPTH];
  cell_flags_t         cell_flags [DEPTH];
  cell_ctrl_t          cell_ctrl [DEPTH];
  logic [DEPTH-1:0]    valid_vec, gt_vec, match_vec, ins_vec;
  logic [31:0]         rd_key_ext, rd_tag_ext;
  logic [31:0]         hd_key_ext, hd_tag_ext;

  assign in_w    = in_word_t'(s_axis_tdata_i);
  assign key_ext = {16'd0, in_w.priority_key};
  assign tag_ext = {16'd0, in_w.payload_tag};
  assign bus_key = key_ext[KEY_BITS-1:0];
  assign in_tag  = tag_ext[TAG_BITS-1:0];
  assign bus_tag = (state_q == S_SCAN) ? tag_q : in_tag;

  assign s_axis_tready_o = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_ok          = (32'(in_w.position) < 32'(cnt_q));
  assign pos_idx         = IdxW'(in_w.position);
  assign scan_idx        = scan_q[IdxW-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0] lk, rk;
    logic [TAG_BITS-1:0] lt, rt;
    if (g == 0) begin : g_first
      assign lk = '0;
      assign lt = '0;
    end else begin : g_mid_l
      assign lk = cell_key[g-1];
      assign lt = cell_tag[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rt = '0;
    end else begin : g_mid_r
      assign rk = cell_key[g+1];
      assign rt = cell_tag[g+1];
    end

    spq_cell #(
      .KEY_BITS(KEY_BITS),
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[g]),
      .new_key_i  (bus_key),
      .new_tag_i  (bus_tag),
      .left_key_i (lk),
      .left_tag_i (lt),
      .right_key_i(rk),
      .right_tag_i(rt),
      .key_o      (cell_key[g]),
      .tag_o      (cell_tag[g]),
      .flags_o    (cell_flags[g])
    );

    assign valid_vec[g] = (32'(g) < 32'(cnt_q));
    assign gt_vec[g]    = valid_vec[g] && cell_flags[g].gt;
    assign match_vec[g] = valid_vec[g] && cell_flags[g].match;
    if (g == 0) begin : g_ins_first
      assign ins_vec[g] = gt_vec[g] || (32'(g) == 32'(cnt_q));
    end else begin : g_ins_mid
      assign ins_vec[g] = (gt_vec[g] || (32'(g) == 32'(cnt_q))) && !gt_vec[g-1];
    end
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_vec[i]) begin
        ins_pos = ins_pos | IdxW'(i);
      end
    end
  end

  assign rd_key_ext = 32'(cell_key[pos_idx]);
  assign rd_tag_ext = 32'(cell_tag[pos_idx]);
  assign hd_key_ext = 32'(cell_key[0]);
  assign hd_tag_ext = 32'(cell_tag[0]);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    scan_d   = scan_q;
    rcnt_d   = rcnt_q;
    out_load = 1'b0;
    out_d    = '0;
    out_d.status = ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].cmd = CELL_HOLD;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          unique case (in_w.opcode)
            OP_INSERT: begin
              if (cnt_q == CntW'(DEPTH)) begin
                out_d.status = ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (i > 0 && gt_vec[(i > 0) ? i - 1 : 0]) begin
                    cell_ctrl[i].cmd = CELL_TAKE_LEFT;
                  end else if (ins_vec[i]) begin
                    cell_ctrl[i].cmd = CELL_LOAD;
                  end
                end
                cnt_d              = cnt_q + CntW'(1);
                out_d.out_position = 4'(ins_pos);
              end
            end
            OP_POLL, OP_PEEK: begin
              if (cnt_q == '0) begin
                out_d.status = ST_RANGE;
              end else begin
                out_d.out_key     = hd_key_ext[15:0];
                out_d.out_payload = hd_tag_ext[15:0];
                if (in_w.opcode == OP_POLL) begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                    cell_ctrl[i].cmd = CELL_TAKE_RIGHT;
                  end
                  cnt_d = cnt_q - CntW'(1);
                end
              end
            end
            OP_READ_AT, OP_REMOVE_AT: begin
              if (!pos_ok) begin
                out_d.status = ST_RANGE;
              end else begin
                out_d.out_key     = rd_key_ext[15:0];
                out_d.out_payload = rd_tag_ext[15:0];
                if (in_w.opcode == OP_REMOVE_AT) begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                    if (32'(i) >= 32'(pos_idx)) begin
                      cell_ctrl[i].cmd = CELL_TAKE_RIGHT;
                    end
                  end
                  cnt_d = cnt_q - CntW'(1);
                end
              end
            end
            OP_REMOVE_TAG: begin
              out_load = 1'b0;
              state_d  = S_SCAN;
              scan_d   = '0;
              rcnt_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_q >= cnt_q) begin
          out_load            = 1'b1;
          out_d.removed_count = 5'(rcnt_q);
          state_d             = S_IDLE;
        end else if (match_vec[scan_idx]) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (32'(i) >= 32'(scan_idx)) begin
              cell_ctrl[i].cmd = CELL_TAKE_RIGHT;
            end
          end
          cnt_d  = cnt_q - CntW'(1);
          rcnt_d = rcnt_q + CntW'(1);
        end else begin
          scan_d = scan_q + CntW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d.entry_count = 5'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      scan_q    <= '0;
      rcnt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      rcnt_q  <= rcnt_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    if (in_fire) begin
      tag_q <= in_tag;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire
